// ----- hdl/nonce_replay_cache_with_expiry_defines.svh -----
// assertion macros for the nonce replay cache
// both macros sample on clk and are disabled while rst_n is low
`ifndef NONCE_REPLAY_CACHE_WITH_EXPIRY_DEFINES_SVH
`define NONCE_REPLAY_CACHE_WITH_EXPIRY_DEFINES_SVH

`ifndef ASSERT_OFF

// property that must hold at every sampled edge
`define NRC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequence that must hold in the cycle after the trigger
`define NRC_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`else

`define NRC_ASSERT_ALWAYS(label, prop, msg)
`define NRC_ASSERT_NEXT(label, trig, prop, msg)

`endif

`endif

// ----- hdl/nrc_pkg.sv -----
package nrc_pkg;

    // default number of table slots
    localparam int NRC_TABLE_ENTRIES = 16;

    // largest value reported on live_entries
    localparam logic [4:0] NRC_COUNT_MAX = 5'd31;

    // result codes
    typedef enum logic [1:0] {
        STATUS_ACCEPTED = 2'd0,
        STATUS_REPLAY   = 2'd1,
        STATUS_FULL     = 2'd2
    } nrc_status_t;

    // request payload
    typedef struct packed {
        logic [63:0]        nonce_high;
        logic [63:0]        nonce_low;
        logic signed [63:0] expire_time;
        logic signed [63:0] now_seconds;
    } nrc_req_t;

    // result payload
    typedef struct packed {
        logic [1:0] status;
        logic [4:0] live_entries;
    } nrc_rsp_t;

    // one stored table entry
    typedef struct packed {
        logic [63:0]        nonce_high;
        logic [63:0]        nonce_low;
        logic signed [63:0] expiry;
    } nrc_entry_t;

    // per-entry verdict from the compare unit
    typedef struct packed {
        logic live;
        logic hit;
    } nrc_match_t;

endpackage

// ----- hdl/nrc_ram.sv -----
module nrc_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/nrc_match_unit.sv -----
module nrc_match_unit
    import nrc_pkg::*;
(
    input  logic               entry_valid,
    input  nrc_entry_t         entry,
    input  logic [63:0]        nonce_high,
    input  logic [63:0]        nonce_low,
    input  logic signed [63:0] now_seconds,
    output nrc_match_t         verdict
);

    logic expired;
    logic same_nonce;

    // signed expiry check, an entry expiring exactly now stays live
    assign expired    = entry.expiry < now_seconds;
    assign same_nonce = (entry.nonce_high == nonce_high) && (entry.nonce_low == nonce_low);

    // live entries take part in the replay check
    assign verdict.live = entry_valid && !expired;
    assign verdict.hit  = entry_valid && !expired && same_nonce;

endmodule

// ----- hdl/nonce_replay_cache_with_expiry.sv -----
// Nonce replay cache with expiry.
// A request is transferred on req at a rising edge where start is high and
// busy is low. busy stays high until the result is out. The result appears
// on result for exactly one cycle with done high; the receiver cannot stall
// it, so it must take it in that cycle.
// The request walks the table once through a single compare unit fed from
// the entry RAM (one read per cycle, registered read): expired entries
// are dropped, live ones are checked for the nonce, and the lowest free slot
// is noted. The finish state writes the new entry if one is inserted and
// issues the result. From the accepting edge the request passes the sweep
// state, which issues the reads and compares the returned entries, and then
// the finish state; one request is in flight at a time and the next start is
// taken at the earliest in the cycle that carries done, so a new request is
// only taken once the last one has issued its result.
// Reset clears every valid bit at once, so the table starts empty and the
// block is ready right after reset. Status is accepted, replay or full;
// live_entries is the number of valid entries after the request, saturating
// at 31.
`include "nonce_replay_cache_with_expiry_defines.svh"

module nonce_replay_cache_with_expiry
    import nrc_pkg::*;
#(
    parameter int TABLE_ENTRIES = NRC_TABLE_ENTRIES
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  nrc_req_t req,
    output logic     done,
    output nrc_rsp_t result
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = $bits(nrc_entry_t);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t               state_reg;
    nrc_req_t             req_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [IW-1:0]        rd_idx_reg;
    logic                 issue_done_reg;
    logic                 pend_reg;
    logic [IW-1:0]        pend_idx_reg;
    logic                 hit_reg;
    logic                 free_found_reg;
    logic [IW-1:0]        free_idx_reg;
    logic [CW-1:0]        live_cnt_reg;
    logic                 done_reg;
    nrc_rsp_t             result_reg;

    logic                 ram_we;
    nrc_entry_t           ram_wentry;
    logic [EW-1:0]        ram_rdata;
    nrc_entry_t           ram_rentry;
    nrc_match_t           verdict;
    logic                 insert;
    logic [CW-1:0]        final_cnt;
    logic [4:0]           live_out;

    // entry storage
    assign ram_we                = (state_reg == ST_FINISH) && insert;
    assign ram_wentry.nonce_high = req_reg.nonce_high;
    assign ram_wentry.nonce_low  = req_reg.nonce_low;
    assign ram_wentry.expiry     = req_reg.expire_time;

    nrc_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata (ram_wentry),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign ram_rentry = nrc_entry_t'(ram_rdata);

    // shared compare unit, one entry per cycle
    nrc_match_unit u_match (
        .entry_valid (valid_reg[pend_idx_reg]),
        .entry       (ram_rentry),
        .nonce_high  (req_reg.nonce_high),
        .nonce_low   (req_reg.nonce_low),
        .now_seconds (req_reg.now_seconds),
        .verdict     (verdict)
    );

    // outcome of the sweep
    assign insert    = !hit_reg && free_found_reg;
    assign final_cnt = live_cnt_reg + CW'(insert);
    assign live_out  = (32'(final_cnt) > 32'(NRC_COUNT_MAX)) ? NRC_COUNT_MAX : 5'(final_cnt);

    // request capture
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            req_reg <= req;
        end
    end

    // sequencer, table valid bits and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            rd_idx_reg     <= '0;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            live_cnt_reg   <= '0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        rd_idx_reg     <= '0;
                        issue_done_reg <= 1'b0;
                        pend_reg       <= 1'b0;
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        live_cnt_reg   <= '0;
                        state_reg      <= ST_SWEEP;
                    end
                end
                ST_SWEEP:
                begin
                    // read issue side
                    pend_reg     <= !issue_done_reg;
                    pend_idx_reg <= rd_idx_reg;
                    if (!issue_done_reg)
                    begin
                        if (rd_idx_reg == LAST_IDX)
                        begin
                            issue_done_reg <= 1'b1;
                        end
                        else
                        begin
                            rd_idx_reg <= rd_idx_reg + IW'(1);
                        end
                    end
                    // compare side: prune, match, first free slot
                    if (pend_reg)
                    begin
                        valid_reg[pend_idx_reg] <= verdict.live;
                        if (verdict.hit)
                        begin
                            hit_reg <= 1'b1;
                        end
                        if (verdict.live)
                        begin
                            live_cnt_reg <= live_cnt_reg + CW'(1);
                        end
                        else if (!free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= pend_idx_reg;
                        end
                        if (pend_idx_reg == LAST_IDX)
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (insert)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                    end
                    if (hit_reg)
                    begin
                        result_reg.status <= STATUS_REPLAY;
                    end
                    else if (!free_found_reg)
                    begin
                        result_reg.status <= STATUS_FULL;
                    end
                    else
                    begin
                        result_reg.status <= STATUS_ACCEPTED;
                    end
                    result_reg.live_entries <= live_out;
                    done_reg  <= 1'b1;
                    pend_reg  <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `NRC_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy && !done, "accepted request did not raise busy")
    `NRC_ASSERT_NEXT(a_done_one_cycle, done, !done, "result strobe held longer than one cycle")
    `NRC_ASSERT_ALWAYS(a_done_ends_busy, $fell(busy) == done, "busy release and result strobe out of step")
    `NRC_ASSERT_ALWAYS(a_status_code, !done || result.status == STATUS_ACCEPTED || result.status == STATUS_REPLAY || result.status == STATUS_FULL, "undefined status code")
    `NRC_ASSERT_ALWAYS(a_accept_counts, !done || result.status != STATUS_ACCEPTED || result.live_entries != 5'd0, "recorded nonce missing from live count")

endmodule
